### design/amet_pkg.sv
// Shared types, widths and codes of the adjacency matrix edge table.
package amet_pkg;

   localparam int CMD_W        = 3;
   localparam int VERTEX_W     = 7;
   localparam int WEIGHT_W     = 16;
   localparam int STATUS_W     = 2;
   localparam int EDGE_COUNT_W = 13;

   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TEST       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ROW_EMPTY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NEXT       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]           cmd;
      logic [VERTEX_W-1:0]        source_vertex;
      logic [VERTEX_W-1:0]        dest_vertex;
      logic signed [WEIGHT_W-1:0] weight_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [WEIGHT_W-1:0] weight_out;
      logic [VERTEX_W-1:0]        next_vertex;
      logic                       row_empty;
      logic [EDGE_COUNT_W-1:0]    edge_count;
   } rsp_type;

   typedef struct packed {
      logic found;
      logic empty;
   } scan_flags_type;

endpackage

### design/amet_row_scan.sv
// Neighbor search and emptiness test over one row of the presence bitmap.
module amet_row_scan #(
   parameter int ROW_W = 64,
   parameter int IDX_W = 6,
   parameter int NV_W  = 7
) (
   input  logic [ROW_W-1:0]              row,
   input  logic [amet_pkg::VERTEX_W-1:0] start_vertex,
   input  logic [NV_W-1:0]               num_vertices,
   output logic [IDX_W-1:0]              hit_index,
   output amet_pkg::scan_flags_type      flags
);
   import amet_pkg::*;

   logic [ROW_W-1:0] in_range;
   logic [ROW_W-1:0] candidates;
   logic [ROW_W-1:0] lowest;

   // A column takes part when it is in use and lies after the start vertex.
   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         in_range[i] = (i < int'(num_vertices));
      end
      candidates = '0;
      for (int i = 0; i < ROW_W; i++) begin
         candidates[i] = row[i] & in_range[i] & (i >= int'(start_vertex));
      end
   end

   // Isolate the lowest set bit, then encode its position.
   assign lowest = candidates & (~candidates + ROW_W'(1));

   always_comb begin
      hit_index = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (lowest[i]) begin
            hit_index = hit_index | IDX_W'(i);
         end
      end
   end

   assign flags.found = |candidates;
   assign flags.empty = ~|(row & in_range);

endmodule

### design/adjacency_matrix_edge_table_unit.sv
// Top level of the adjacency matrix edge table: command decode, memories and result register.
//
// The unit keeps a weighted directed graph as an adjacency matrix. Each source row is one
// word of a presence memory, and each edge weight sits in a weight memory addressed by the
// pair of row and column. A request is taken at a clock edge where start is high and busy is
// low. The edge that takes it also reads the row word and the weight; the following cycle
// (busy high) decides the command, writes the row and weight back, and registers the
// result, which shows on rsp_item with rsp_valid high for exactly one cycle. The receiver
// cannot hold a result off, so it must take it in that cycle. A new request is accepted at
// the edge that ends the result cycle; none is taken while another is in its operation
// cycle. The read-modify-write of the row memory, a read and then a write-back, requires it
// and also keeps a read from ever overlapping a write to the same row. Clearing the graph,
// by the clear command, a vertex count write or reset, takes effect at once through one
// valid bit per row; a row whose bit is low reads as empty. The user writes the vertex
// count through csr_write_en and csr_write_data only while the unit is idle, which the unit
// does not enforce. Zero is taken as one, a value above MAX_VERTICES as MAX_VERTICES.
module adjacency_matrix_edge_table_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  amet_pkg::req_type             req_item,
   output logic                          rsp_valid,
   output amet_pkg::rsp_type             rsp_item,
   input  logic                          csr_write_en,
   input  logic [amet_pkg::VERTEX_W-1:0] csr_write_data
);
   import amet_pkg::*;

   localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int ROWS   = 1 << IDX_W;
   localparam int NV_W   = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W  = (NV_W > VERTEX_W) ? NV_W : VERTEX_W;
   localparam int WADDR_W = 2 * IDX_W;

   // Vertex count register.
   logic [NV_W-1:0] nv_ff, nv_in;

   // Operation stage: the request in flight while its memory words come back.
   logic                    op_valid_ff;
   logic [CMD_W-1:0]        cmd_ff;
   logic                    src_ok_ff;
   logic                    pair_ok_ff;
   logic [IDX_W-1:0]        r_ff;
   logic [IDX_W-1:0]        c_ff;
   logic [VERTEX_W-1:0]     dst_ff;
   logic signed [WEIGHT_W-1:0] win_ff;

   logic                    accept;
   logic                    src_ok, dst_ok;
   logic [IDX_W-1:0]        acc_row, acc_col;

   // Memories and their read registers.
   logic [ROWS-1:0]              row_mem [ROWS];
   logic [ROWS-1:0]              row_rd_ff;
   logic [WEIGHT_BITS-1:0]       weight_mem [1 << WADDR_W];
   logic signed [WEIGHT_BITS-1:0] weight_rd_ff;
   logic [ROWS-1:0]              row_valid_ff, row_valid_in;

   logic [EDGE_COUNT_W-1:0] total_ff, total_in;

   // Decode of the operation stage.
   logic [ROWS-1:0]         row_data;
   logic                    edge_bit;
   logic [ROWS-1:0]         row_new;
   logic                    row_we;
   logic                    weight_we;
   logic [63:0]             win_wide;
   logic [63:0]             wrd_wide;
   logic [IDX_W-1:0]        hit_index;
   logic [IDX_W:0]          next_wide;
   scan_flags_type          scan_flags;
   logic                    clear_all;
   rsp_type                 rsp_in, rsp_ff;
   logic                    rsp_valid_ff;

   assign accept = start && !busy;
   assign busy   = op_valid_ff;

   // A vertex is in range when it lies in 1 .. vertex count.
   assign src_ok = (req_item.source_vertex != '0) &&
                   (CMP_W'(req_item.source_vertex) <= CMP_W'(nv_ff));
   assign dst_ok = (req_item.dest_vertex != '0) &&
                   (CMP_W'(req_item.dest_vertex) <= CMP_W'(nv_ff));
   assign acc_row = IDX_W'(req_item.source_vertex - VERTEX_W'(1));
   assign acc_col = IDX_W'(req_item.dest_vertex - VERTEX_W'(1));

   // Clamp of a new vertex count into 1 .. MAX_VERTICES.
   always_comb begin
      if (csr_write_data == '0) begin
         nv_in = NV_W'(1);
      end else if (CMP_W'(csr_write_data) > CMP_W'(MAX_VERTICES)) begin
         nv_in = NV_W'(MAX_VERTICES);
      end else begin
         nv_in = NV_W'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= NV_W'(MAX_VERTICES);
      end else if (csr_write_en) begin
         nv_ff <= nv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_item.cmd;
         src_ok_ff  <= src_ok;
         pair_ok_ff <= src_ok && dst_ok;
         r_ff       <= acc_row;
         c_ff       <= acc_col;
         dst_ff     <= req_item.dest_vertex;
         win_ff     <= req_item.weight_in;
      end
   end

   // Presence memory: read at acceptance, written back in the operation cycle.
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[r_ff] <= row_new;
      end
      if (accept) begin
         row_rd_ff <= row_mem[acc_row];
      end
   end

   // Weight memory, addressed by row and column side by side.
   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[{r_ff, c_ff}] <= win_wide[WEIGHT_BITS-1:0];
      end
      if (accept) begin
         weight_rd_ff <= weight_mem[{acc_row, acc_col}];
      end
   end

   // A row not written since the last clear reads as empty.
   assign row_data = row_valid_ff[r_ff] ? row_rd_ff : '0;
   assign edge_bit = row_data[c_ff];

   assign win_wide  = 64'(win_ff);
   assign wrd_wide  = 64'(weight_rd_ff);
   assign next_wide = (IDX_W+1)'(hit_index) + (IDX_W+1)'(1);

   amet_row_scan #(
      .ROW_W (ROWS),
      .IDX_W (IDX_W),
      .NV_W  (NV_W)
   ) u_scan (
      .row          (row_data),
      .start_vertex (dst_ff),
      .num_vertices (nv_ff),
      .hit_index    (hit_index),
      .flags        (scan_flags)
   );

   // Command decode in the operation cycle.
   always_comb begin
      row_new   = row_data;
      row_we    = 1'b0;
      weight_we = 1'b0;
      clear_all = 1'b0;
      total_in  = total_ff;
      rsp_in.status      = ST_OK;
      rsp_in.weight_out  = '0;
      rsp_in.next_vertex = '0;
      rsp_in.row_empty   = 1'b0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (!pair_ok_ff) begin
               rsp_in.status = ST_RANGE;
            end else begin
               weight_we     = op_valid_ff;
               row_we        = op_valid_ff;
               row_new[c_ff] = 1'b1;
               if (!edge_bit) begin
                  total_in = total_ff + EDGE_COUNT_W'(1);
               end
            end
         end
         CMD_TEST, CMD_REMOVE: begin
            if (!pair_ok_ff) begin
               rsp_in.status = ST_RANGE;
            end else if (!edge_bit) begin
               rsp_in.status = ST_NONE;
            end else begin
               rsp_in.weight_out = signed'(wrd_wide[WEIGHT_W-1:0]);
               if (cmd_ff == CMD_REMOVE) begin
                  row_we        = op_valid_ff;
                  row_new[c_ff] = 1'b0;
                  total_in      = total_ff - EDGE_COUNT_W'(1);
               end
            end
         end
         CMD_ROW_EMPTY: begin
            rsp_in.row_empty = 1'b1;
            if (!src_ok_ff) begin
               rsp_in.status = ST_RANGE;
            end else begin
               rsp_in.row_empty = scan_flags.empty;
            end
         end
         CMD_NEXT: begin
            if (!src_ok_ff) begin
               rsp_in.status = ST_RANGE;
            end else if (scan_flags.found) begin
               rsp_in.next_vertex = VERTEX_W'(next_wide);
            end else begin
               rsp_in.status = ST_NONE;
            end
         end
         CMD_CLEAR: begin
            clear_all = op_valid_ff;
            total_in  = '0;
         end
         default: begin
         end
      endcase
      rsp_in.edge_count = total_in;
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (clear_all) begin
         row_valid_in = '0;
      end else if (row_we) begin
         row_valid_in[r_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_en) begin
         row_valid_ff <= '0;
         total_ff     <= '0;
      end else if (op_valid_ff) begin
         row_valid_ff <= row_valid_in;
         total_ff     <= total_in;
      end
   end

   // Result register: each result is shown for exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= op_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (op_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Every accepted request occupies the operation stage in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not enter the operation stage");

   // The operation cycle is always followed by exactly one result strobe.
   a_op_result: assert property (@(posedge clock) disable iff (reset)
      op_valid_ff |=> rsp_valid_ff)
      else $error("operation finished without a result strobe");

   // A result cycle never overlaps an operation cycle, so row writes cannot race reads.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid_ff && op_valid_ff))
      else $error("result cycle overlaps an operation cycle");

   // The vertex count stays inside 1 .. MAX_VERTICES.
   a_nv_range: assert property (@(posedge clock) disable iff (reset)
      (nv_ff != '0) && (CMP_W'(nv_ff) <= CMP_W'(MAX_VERTICES)))
      else $error("vertex count out of range");

endmodule

### sim/edge_table_checker.sv
// Checker for the edge table: predicts each result from the observed requests and compares it.
module edge_table_checker #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  amet_pkg::req_type             req_item,
   input  logic                          rsp_valid,
   input  amet_pkg::rsp_type             rsp_item,
   input  logic                          csr_write_en,
   input  logic [amet_pkg::VERTEX_W-1:0] csr_write_data,
   output int                            mismatch_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import amet_pkg::*;

   localparam int REPORT_CAP = 100;

   logic [MAX_VERTICES-1:0]    adj_bits [MAX_VERTICES];
   logic signed [WEIGHT_W-1:0] edge_weights [MAX_VERTICES][MAX_VERTICES];
   int                         edge_tally;
   int                         vertex_count;
   rsp_type                    expected_replies [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Weights need no clearing: one is only read once its edge is present again.
   function automatic void clear_graph();
      foreach (adj_bits[r]) adj_bits[r] = '0;
      edge_tally = 0;
   endfunction

   function automatic rsp_type apply_graph_command(input req_type item);
      rsp_type reply;
      logic    src_ok;
      logic    dst_ok;
      int      row;
      int      col;
      reply  = '0;
      src_ok = item.source_vertex >= 1 && item.source_vertex <= vertex_count;
      dst_ok = item.dest_vertex >= 1 && item.dest_vertex <= vertex_count;
      row    = int'(item.source_vertex) - 1;
      col    = int'(item.dest_vertex) - 1;
      case (item.cmd)
         CMD_INSERT: begin
            if (!(src_ok && dst_ok)) begin
               reply.status = ST_RANGE;
            end else begin
               edge_weights[row][col] = item.weight_in;
               if (!adj_bits[row][col]) begin
                  adj_bits[row][col] = 1'b1;
                  edge_tally++;
               end
            end
         end
         CMD_TEST, CMD_REMOVE: begin
            if (!(src_ok && dst_ok)) begin
               reply.status = ST_RANGE;
            end else if (!adj_bits[row][col]) begin
               reply.status = ST_NONE;
            end else begin
               reply.weight_out = edge_weights[row][col];
               if (item.cmd == CMD_REMOVE) begin
                  adj_bits[row][col] = 1'b0;
                  edge_tally--;
               end
            end
         end
         CMD_ROW_EMPTY: begin
            reply.row_empty = 1'b1;
            if (!src_ok) begin
               reply.status = ST_RANGE;
            end else if (adj_bits[row] != '0) begin
               reply.row_empty = 1'b0;
            end
         end
         CMD_NEXT: begin
            if (!src_ok) begin
               reply.status = ST_RANGE;
            end else begin
               // The scan starts just after the given vertex, so column index dest.
               reply.status = ST_NONE;
               for (int i = int'(item.dest_vertex); i < vertex_count; i++) begin
                  if (reply.status == ST_NONE && adj_bits[row][i]) begin
                     reply.status      = ST_OK;
                     reply.next_vertex = VERTEX_W'(i + 1);
                  end
               end
            end
         end
         CMD_CLEAR: clear_graph();
         default: ;
      endcase
      reply.edge_count = EDGE_COUNT_W'(edge_tally);
      return reply;
   endfunction

   task automatic flag_mismatch(input string field, input logic signed [31:0] expected_value,
                                input logic signed [31:0] actual_value);
      if (mismatch_count < REPORT_CAP)
         $error("%s: expected %0d, got %0d", field, expected_value, actual_value);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      int      clamped;
      if (reset) begin
         vertex_count = MAX_VERTICES;
         clear_graph();
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               flag_mismatch("unexpected result, status", 0, rsp_item.status);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_item.status !== want.status)
                  flag_mismatch("status", want.status, rsp_item.status);
               if (rsp_item.weight_out !== want.weight_out)
                  flag_mismatch("weight_out", want.weight_out, rsp_item.weight_out);
               if (rsp_item.next_vertex !== want.next_vertex)
                  flag_mismatch("next_vertex", want.next_vertex, rsp_item.next_vertex);
               if (rsp_item.row_empty !== want.row_empty)
                  flag_mismatch("row_empty", want.row_empty, rsp_item.row_empty);
               if (rsp_item.edge_count !== want.edge_count)
                  flag_mismatch("edge_count", want.edge_count, rsp_item.edge_count);
            end
         end
         if (csr_write_en) begin
            clamped = int'(csr_write_data);
            if (clamped < 1) clamped = 1;
            if (clamped > MAX_VERTICES) clamped = MAX_VERTICES;
            vertex_count = clamped;
            clear_graph();
         end
         if (start && !busy)
            expected_replies.push_back(apply_graph_command(req_item));
         pending_count = expected_replies.size();
      end
   end

endmodule

### sim/adjacency_matrix_edge_table_unit_tb.sv
// Testbench top of the edge table: clock, reset, request stimulus, vertex-count phases, verdict.
module adjacency_matrix_edge_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import amet_pkg::*;

   localparam int VERTEX_LIMIT = 64;
   localparam int HALF_PERIOD  = 5;
   // Commands 6 and 7 are not defined; the unit must leave the graph alone for them.
   localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;
   // Requests numbered in this window get no random idle gaps put in front of them.
   localparam int QUIET_FIRST  = 400;
   localparam int QUIET_LAST   = 650;
   localparam int PHASE_ITEMS  = 160;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   req_type               req_item       = '0;
   logic                  rsp_valid;
   rsp_type               rsp_item;
   logic                  csr_write_en   = 1'b0;
   logic [VERTEX_W-1:0]   csr_write_data = '0;

   int mismatches;
   int outstanding;
   int requests_sent  = 0;
   int settings_used  = 0;
   // The tester's own view of the active vertex count, used only to aim the stimulus.
   int vertex_count   = VERTEX_LIMIT;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   adjacency_matrix_edge_table_unit #(
      .MAX_VERTICES (VERTEX_LIMIT),
      .WEIGHT_BITS  (WEIGHT_W)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // The checker sits beside the unit, predicting every result from the requests it sees
   // accepted and comparing the result strobes against those predictions.
   edge_table_checker #(
      .MAX_VERTICES (VERTEX_LIMIT)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatches),
      .pending_count  (outstanding)
   );

   // Hard stop in case the unit stops accepting requests or stops returning results.
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type build_request(input logic [CMD_W-1:0] op, input int src,
                                             input int dst, input int weight);
      req_type item;
      item.cmd           = op;
      item.source_vertex = src[VERTEX_W-1:0];
      item.dest_vertex   = dst[VERTEX_W-1:0];
      item.weight_in     = weight[WEIGHT_W-1:0];
      return item;
   endfunction

   // Many vertices come from a small cluster so that edges get hit again, with the top
   // vertex and out-of-range values (including 0 and up to 127) mixed in.
   function automatic logic [VERTEX_W-1:0] pick_vertex();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)  return VERTEX_W'($urandom_range(0, 127));
      if (pick < 20) return VERTEX_W'(vertex_count);
      if (pick < 65) return VERTEX_W'($urandom_range(1, vertex_count < 6 ? vertex_count : 6));
      return VERTEX_W'($urandom_range(1, vertex_count));
   endfunction

   function automatic req_type random_request();
      req_type item;
      int      pick;
      item.source_vertex = pick_vertex();
      item.dest_vertex   = pick_vertex();
      pick = $urandom_range(0, 99);
      if (pick < 5)       item.weight_in = 16'sh8000;
      else if (pick < 10) item.weight_in = 16'sh7FFF;
      else if (pick < 13) item.weight_in = '0;
      else if (pick < 16) item.weight_in = 16'shFFFF;
      else                item.weight_in = WEIGHT_W'($urandom);
      // Clears stay rare so the graph has time to fill between them.
      pick = $urandom_range(0, 99);
      if (pick < 34)      item.cmd = CMD_INSERT;
      else if (pick < 52) item.cmd = CMD_TEST;
      else if (pick < 66) item.cmd = CMD_REMOVE;
      else if (pick < 74) item.cmd = CMD_ROW_EMPTY;
      else if (pick < 92) begin
         item.cmd = CMD_NEXT;
         if ($urandom_range(0, 3) == 0) item.dest_vertex = '0;
      end
      else if (pick < 93) item.cmd = CMD_CLEAR;
      else if (pick < 96) item.cmd = CMD_RESERVED_LO;
      else                item.cmd = CMD_RESERVED_HI;
      return item;
   endfunction

   // Presents one request and returns right after the clock edge that accepted it, with
   // start still high. Idle gaps of varying length are put in front of some requests so
   // that they land on both the accepting cycle and the busy cycle of the unit.
   task automatic send_request(input req_type item);
      if (!(requests_sent >= QUIET_FIRST && requests_sent < QUIET_LAST) &&
          $urandom_range(0, 99) < 16) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   // Holds off new requests until every predicted result has come back. The pending
   // count is read at the falling edge, where the checker's update has settled.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Writes the vertex count while the unit is idle; the write also empties the graph.
   task automatic write_vertex_count(input int value);
      drain();
      repeat (2) @(posedge clock);
      csr_write_data <= VERTEX_W'(value);
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      vertex_count = value < 1 ? 1 : (value > VERTEX_LIMIT ? VERTEX_LIMIT : value);
      settings_used++;
   endtask

   initial begin
      int plan [8] = '{1, 0, 2, 127, 65, 5, VERTEX_LIMIT, 12};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset vertex count of 64: weight extremes, overwriting an
      // existing edge without counting it twice, both vertices out of range in turn,
      // removing twice, empty and non-empty rows, neighbor scans that hit, that start
      // at or beyond the last vertex and that run over an empty row, the two undefined
      // commands, and a clear followed by a test.
      send_request(build_request(CMD_INSERT, 1, 1, -32768));
      send_request(build_request(CMD_INSERT, 64, 64, 32767));
      send_request(build_request(CMD_INSERT, 1, 64, 16'h5555));
      send_request(build_request(CMD_INSERT, 1, 1, 16'h2AAA));
      send_request(build_request(CMD_TEST, 1, 1, 0));
      send_request(build_request(CMD_TEST, 64, 64, 0));
      send_request(build_request(CMD_TEST, 2, 2, 0));
      send_request(build_request(CMD_INSERT, 0, 5, 7));
      send_request(build_request(CMD_INSERT, 5, 65, 7));
      send_request(build_request(CMD_TEST, 127, 127, -1));
      send_request(build_request(CMD_REMOVE, 1, 64, 0));
      send_request(build_request(CMD_REMOVE, 1, 64, 0));
      send_request(build_request(CMD_ROW_EMPTY, 1, 0, 0));
      send_request(build_request(CMD_ROW_EMPTY, 2, 0, 0));
      send_request(build_request(CMD_ROW_EMPTY, 0, 0, 0));
      send_request(build_request(CMD_NEXT, 1, 0, 0));
      send_request(build_request(CMD_NEXT, 64, 63, 0));
      send_request(build_request(CMD_NEXT, 64, 64, 0));
      send_request(build_request(CMD_NEXT, 3, 0, 0));
      send_request(build_request(CMD_NEXT, 0, 0, 0));
      send_request(build_request(CMD_RESERVED_LO, 1, 1, 5));
      send_request(build_request(CMD_RESERVED_HI, 64, 64, -5));
      send_request(build_request(CMD_CLEAR, 0, 0, 0));
      send_request(build_request(CMD_TEST, 64, 64, 0));

      // Random part: one phase per vertex-count setting, including zero, one, the maximum
      // and values above it, each starting from an empty graph.
      foreach (plan[p]) begin
         write_vertex_count(plan[p]);
         repeat (PHASE_ITEMS) send_request(random_request());
      end

      drain();
      repeat (4) @(posedge clock);

      $display("Run covered %0d requests over %0d vertex-count settings after the directed set,",
               requests_sent, settings_used);
      $display("including a stretch of back-to-back requests and idle waits between phases.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
design/amet_pkg.sv
design/amet_row_scan.sv
design/adjacency_matrix_edge_table_unit.sv
sim/edge_table_checker.sv
sim/adjacency_matrix_edge_table_unit_tb.sv
